// File: hw/rtl/tcg_pkg.sv
`default_nettype none

package tcg_pkg;

  // Fixed glyph geometry and default build values
  localparam int unsigned GLYPH_WIDTH      = 8;
  localparam int unsigned GLYPH_HEIGHT_DEF = 8;
  localparam int unsigned PIXEL_SCALE_DEF  = 2;
  localparam int unsigned LINE_GAP_DEF     = 2;
  localparam int unsigned COORD_BITS_DEF   = 12;

  // Field widths
  localparam int unsigned FONT_DEPTH = 2048;
  localparam int unsigned FONT_AW    = 11;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned ADDR_W     = 25;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned SW_W       = 13;
  localparam int unsigned SH_W       = 13;
  localparam int unsigned PITCH_W    = 14;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // Reset values of the configuration registers
  localparam logic [SW_W-1:0]    SW_RESET    = 13'd640;
  localparam logic [SH_W-1:0]    SH_RESET    = 13'd480;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 14'd640;

  localparam logic [COLOR_W-1:0] FILL_COLOR   = 32'hFF0000FF;
  localparam logic [CODE_W-1:0]  NEWLINE_CODE = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_LINE_PITCH    = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    FUNC_DRAW = 1'b0,
    FUNC_LOAD = 1'b1
  } func_e;

  typedef enum logic {
    KIND_SPAN   = 1'b0,
    KIND_SCROLL = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SPAN,
    ST_FINISH,
    ST_SCROLL
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic font_wr;
    logic setup;
    logic emit_span;
    logic finish;
    logic emit_scroll;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic newline;
    logic last_span;
    logic scroll;
    logic slot_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcg_ifs.sv
`default_nettype none

// Character / font load channel
interface tcg_char_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  char_code;
  logic [31:0] pixel_color;
  logic [10:0] font_address;
  logic [7:0]  font_byte;

  modport source (output valid, func, char_code, pixel_color, font_address, font_byte,
                  input ready);
  modport sink (input valid, func, char_code, pixel_color, font_address, font_byte,
                output ready);
endinterface

// Span / scroll result channel
interface tcg_span_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [24:0] pixel_address;
  logic [15:0] span_mask;
  logic [31:0] span_color;
  logic        last;

  modport source (output valid, kind, pixel_address, span_mask, span_color, last,
                  input ready);
  modport sink (input valid, kind, pixel_address, span_mask, span_color, last,
                output ready);
endinterface

// Register write channel
interface tcg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tcg_ram.sv
`default_nettype none

module tcg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/tcg_ctrl.sv
`default_nettype none

module tcg_ctrl
  import tcg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_func_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_func_i == FUNC_DRAW)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = status_i.newline ? ST_FINISH : ST_SPAN;
      end
      ST_SPAN: begin
        if (status_i.slot_free && status_i.last_span) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = status_i.scroll ? ST_SCROLL : ST_IDLE;
      end
      ST_SCROLL: begin
        if (status_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_LOAD) begin
            cmd_o.font_wr = 1'b1;
          end else begin
            cmd_o.capture = 1'b1;
          end
        end
      end
      ST_SETUP:  cmd_o.setup = 1'b1;
      ST_SPAN:   cmd_o.emit_span = status_i.slot_free;
      ST_FINISH: cmd_o.finish = 1'b1;
      ST_SCROLL: cmd_o.emit_scroll = status_i.slot_free;
      default: ;
    endcase
  end

  // the final span always hands over to the cursor update
  a_span_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPAN && status_i.slot_free && status_i.last_span) |=>
    state_q == ST_FINISH)
    else $error("span sequence did not end in cursor update");

  // a pending scroll is never dropped
  a_scroll_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && status_i.scroll) |=> state_q == ST_SCROLL)
    else $error("scroll command skipped");

endmodule

`default_nettype wire

// File: hw/rtl/tcg_datapath.sv
`default_nettype none

module tcg_datapath
  import tcg_pkg::*;
#(
  parameter int unsigned GlyphHeight = GLYPH_HEIGHT_DEF,
  parameter int unsigned PixelScale  = PIXEL_SCALE_DEF,
  parameter int unsigned LineGap     = LINE_GAP_DEF,
  parameter int unsigned CoordBits   = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // register writes
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input item fields
  input  wire logic [CODE_W-1:0]     char_code_i,
  input  wire logic [COLOR_W-1:0]    pixel_color_i,
  input  wire logic [FONT_AW-1:0]    font_address_i,
  input  wire logic [7:0]            font_byte_i,
  // result register
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       kind_o,
  output logic [ADDR_W-1:0]          pixel_address_o,
  output logic [MASK_W-1:0]          span_mask_o,
  output logic [COLOR_W-1:0]         span_color_o,
  output logic                       last_o,
  // control
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o
);

  localparam int unsigned CellW   = GLYPH_WIDTH * PixelScale;
  localparam int unsigned LineAdv = (GlyphHeight + LineGap) * PixelScale;
  localparam int unsigned CmpW    = CoordBits + 3;
  localparam int unsigned GyW     = $clog2(GlyphHeight);
  localparam int unsigned SyW     = (PixelScale > 1) ? $clog2(PixelScale) : 1;

  // configuration
  logic [SW_W-1:0]    sw_q;
  logic [SH_W-1:0]    sh_q;
  logic [PITCH_W-1:0] pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= SW_RESET;
      sh_q    <= SH_RESET;
      pitch_q <= PITCH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  sw_q    <= cfg_data_i[SW_W-1:0];
        CFG_SCREEN_HEIGHT: sh_q    <= cfg_data_i[SH_W-1:0];
        CFG_LINE_PITCH:    pitch_q <= cfg_data_i[PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // cursor and per-character control state
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic                 nl_q, nl_d, scroll_q, scroll_d;
  logic [GyW-1:0]       gy_q;
  logic [SyW-1:0]       sy_q;
  logic                 out_valid_q, out_valid_d;

  // captured item and span datapath
  logic [CODE_W-1:0]  code_q;
  logic [COLOR_W-1:0] color_q;
  logic [FONT_AW-1:0] fbase_q;
  logic [ADDR_W-1:0]  row_addr_q;
  logic [CmpW-1:0]    y_q;
  logic [MASK_W-1:0]  clip_q, clip_d;

  logic               out_kind_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [MASK_W-1:0]  out_mask_q;
  logic [COLOR_W-1:0] out_color_q;
  logic               out_last_q;

  logic [CmpW-1:0]    col_ext, row_ext, sw_ext, sh_ext, row_adv;
  logic [CmpW:0]      rem;
  logic               newline, last_span, sy_wrap, slot_free, rd_en;
  logic [GyW:0]       rd_row;
  logic [FONT_AW-1:0] rd_addr;
  logic [7:0]         font_row;
  logic [MASK_W-1:0]  glyph_mask, span_mask;

  assign col_ext = CmpW'(col_q);
  assign row_ext = CmpW'(row_q);
  assign sw_ext  = CmpW'(sw_q);
  assign sh_ext  = CmpW'(sh_q);
  assign row_adv = row_ext + CmpW'(LineAdv);
  assign newline = (code_q == NEWLINE_CODE);

  // line break and scroll decisions, taken before any span goes out
  assign nl_d     = newline || ((col_ext + CmpW'(2 * CellW)) > sw_ext);
  assign scroll_d = nl_d && (row_adv >= sh_ext);

  // pixels left to the right edge
  assign rem = {1'b0, sw_ext} - {1'b0, col_ext};

  assign sy_wrap   = (sy_q == SyW'(PixelScale - 1));
  assign last_span = sy_wrap && (gy_q == GyW'(GlyphHeight - 1));
  assign slot_free = !out_valid_q || out_ready_i;

  // glyph bits scaled out horizontally, and right edge clipping
  for (genvar i = 0; i < MASK_W; i++) begin : g_mask
    if (i < CellW) begin : g_on
      assign glyph_mask[i] = font_row[GLYPH_WIDTH - 1 - i / PixelScale];
    end else begin : g_off
      assign glyph_mask[i] = 1'b0;
    end
    assign clip_d[i] = !rem[CmpW] && (rem[CmpW-1:0] > CmpW'(i));
  end

  // rows below the screen still give a span, with nothing set
  assign span_mask = (y_q < sh_ext) ? (glyph_mask & clip_q) : '0;

  // font fetch: first row at setup, next row with the last scaled copy of a row
  assign rd_en   = cmd_i.setup || (cmd_i.emit_span && sy_wrap);
  assign rd_row  = cmd_i.setup ? '0 : ((GyW+1)'(gy_q) + 1'b1);
  assign rd_addr = fbase_q + FONT_AW'(rd_row);

  tcg_ram #(
    .Width (8),
    .Depth (FONT_DEPTH)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (cmd_i.font_wr),
    .waddr_i (font_address_i),
    .wdata_i (font_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (font_row)
  );

  // cursor update
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.finish) begin
      col_d = nl_q ? '0 : CoordBits'(col_ext + CmpW'(CellW));
      if (nl_q && !scroll_q) begin
        row_d = CoordBits'(row_adv);
      end
    end
  end

  // result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_span || cmd_i.emit_scroll) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      nl_q        <= 1'b0;
      scroll_q    <= 1'b0;
      gy_q        <= '0;
      sy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.setup) begin
        nl_q     <= nl_d;
        scroll_q <= scroll_d;
        gy_q     <= '0;
        sy_q     <= '0;
      end else if (cmd_i.emit_span) begin
        if (sy_wrap) begin
          sy_q <= '0;
          gy_q <= gy_q + 1'b1;
        end else begin
          sy_q <= sy_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      code_q  <= char_code_i;
      color_q <= pixel_color_i;
      fbase_q <= FONT_AW'(char_code_i * GlyphHeight);
    end
    if (cmd_i.setup) begin
      row_addr_q <= ADDR_W'(row_q * pitch_q);
      y_q        <= row_ext;
      clip_q     <= clip_d;
    end else if (cmd_i.emit_span) begin
      row_addr_q <= row_addr_q + ADDR_W'(pitch_q);
      y_q        <= y_q + 1'b1;
    end
    if (cmd_i.emit_span) begin
      out_kind_q  <= KIND_SPAN;
      out_addr_q  <= row_addr_q + ADDR_W'(col_q);
      out_mask_q  <= span_mask;
      out_color_q <= color_q;
      out_last_q  <= last_span && !scroll_q;
    end else if (cmd_i.emit_scroll) begin
      out_kind_q  <= KIND_SCROLL;
      out_addr_q  <= '0;
      out_mask_q  <= '0;
      out_color_q <= FILL_COLOR;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_kind_q;
  assign pixel_address_o = out_addr_q;
  assign span_mask_o     = out_mask_q;
  assign span_color_o    = out_color_q;
  assign last_o          = out_last_q;

  assign status_o.newline   = newline;
  assign status_o.last_span = last_span;
  assign status_o.scroll    = scroll_q;
  assign status_o.slot_free = slot_free;

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_span || cmd_i.emit_scroll) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a scroll command goes out as the final result of its item
  a_scroll_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_scroll |=> (out_valid_q && (out_kind_q == KIND_SCROLL) && out_last_q))
    else $error("scroll command not marked last");

  // scrolling only happens on a line break
  a_scroll_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scroll_q |-> nl_q)
    else $error("scroll without line break");

endmodule

`default_nettype wire

// File: hw/rtl/text_console_glyph_renderer.sv
`default_nettype none

// Channel   Dir  Fields                                                   Accepted when
// cfg_i     in   index, data                                              valid & ready
// in_i      in   func, char_code, pixel_color, font_address, font_byte   valid & ready
// out_o     out  kind, pixel_address, span_mask, span_color, last        valid & ready
//
// Font load: written on acceptance. Character: accept, setup, GlyphHeight*PixelScale
// spans at one span per cycle from the span sequencer while out_o is not stalled,
// cursor update, then any scroll command. Newline: the same steps without the spans.
// Reset clears the cursor and loads the default screen registers; the font store is
// not cleared. A stalled out_o holds the span sequencer; cfg_i is always ready.

module text_console_glyph_renderer
  import tcg_pkg::*;
#(
  parameter int unsigned GlyphHeight = GLYPH_HEIGHT_DEF,
  parameter int unsigned PixelScale  = PIXEL_SCALE_DEF,
  parameter int unsigned LineGap     = LINE_GAP_DEF,
  parameter int unsigned CoordBits   = COORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tcg_cfg_if.sink     cfg_i,
  tcg_char_if.sink    in_i,
  tcg_span_if.source  out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  tcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcg_datapath #(
    .GlyphHeight (GlyphHeight),
    .PixelScale  (PixelScale),
    .LineGap     (LineGap),
    .CoordBits   (CoordBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .char_code_i     (in_i.char_code),
    .pixel_color_i   (in_i.pixel_color),
    .font_address_i  (in_i.font_address),
    .font_byte_i     (in_i.font_byte),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .kind_o          (out_o.kind),
    .pixel_address_o (out_o.pixel_address),
    .span_mask_o     (out_o.span_mask),
    .span_color_o    (out_o.span_color),
    .last_o          (out_o.last),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

`default_nettype wire
